// ===== rtl/amc_pkg.sv =====
`default_nettype none
package amc_pkg;

  localparam int unsigned MatElems = 12;
  localparam logic [31:0] CanonNan = 32'h7FC00000;

  typedef struct packed {
    logic [4:0]  element_index;
    logic [31:0] element_value;
    logic        start_compute;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  result_row;
    logic [1:0]  result_col;
    logic [31:0] result_value;
    logic        result_last;
  } out_word_t;

  // Datapath operation selects.
  typedef enum logic [1:0] {
    OP_MUL0 = 2'd0,
    OP_MAC1 = 2'd1,
    OP_MAC2 = 2'd2,
    OP_ADDT = 2'd3
  } op_t;

  typedef struct packed {
    logic       wr_en;
    logic [4:0] wr_idx;
    logic       op_en;
    op_t        op;
    logic [1:0] row;
    logic [1:0] col;
  } dp_cmd_t;

  typedef struct packed {
    logic        add_done;
  } dp_stat_t;

  // IEEE single multiply, round to nearest even, canonical NaN.
  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic        s;
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic [47:0] p;
    logic signed [10:0] e;
    logic [5:0]  lz;
    logic [49:0] sh;
    logic [24:0] m;
    logic        g, st;
    logic signed [10:0] rs;
    begin
      s  = a[31] ^ b[31];
      ea = a[30:23];
      eb = b[30:23];
      fmul = 32'd0;
      if ((ea == 8'hFF && a[22:0] != 0) || (eb == 8'hFF && b[22:0] != 0)) begin
        fmul = CanonNan;
      end else if (ea == 8'hFF || eb == 8'hFF) begin
        if ((ea == 8'hFF && eb == 8'd0 && b[22:0] == 0) ||
            (eb == 8'hFF && ea == 8'd0 && a[22:0] == 0)) fmul = CanonNan;
        else fmul = {s, 8'hFF, 23'd0};
      end else if ((ea == 0 && a[22:0] == 0) || (eb == 0 && b[22:0] == 0)) begin
        fmul = {s, 31'd0};
      end else begin
        ma = {ea != 0, a[22:0]};
        mb = {eb != 0, b[22:0]};
        p  = ma * mb;
        // Value = p * 2^(e-47-127), e computed from biased exponents.
        e  = 11'(ea == 0 ? 1 : ea) + 11'(eb == 0 ? 1 : eb) - 11'sd126;
        lz = 6'd0;
        for (int i = 47; i >= 0; i--) begin
          if (p[i] && lz == 6'd0) lz = 6'(48 - i);
        end
        lz = lz - 6'd1;
        // Normalize so the leading one sits at bit 47.
        p = p << lz;
        e = e - 11'(lz);
        // Leading one at 47 means exponent e (biased).
        if (e <= 0) begin
          rs = 11'sd1 - e;
          if (rs > 11'sd49) rs = 11'sd49;
          sh = {p, 2'b00} >> rs;
          st = |({p, 2'b00} & ~(50'h3FFFFFFFFFFFF << rs)) ;
          e  = 11'sd0;
        end else begin
          sh = {p, 2'b00};
          st = 1'b0;
        end
        m  = {1'b0, sh[49:26]};
        g  = sh[25];
        st = st | (|sh[24:0]);
        if (g && (st || m[0])) m = m + 25'd1;
        if (e == 0) begin
          fmul = {s, 7'd0, m[23], m[22:0]};
        end else begin
          if (m[24]) begin
            m = m >> 1;
            e = e + 11'sd1;
          end
          if (e >= 11'sd255) fmul = {s, 8'hFF, 23'd0};
          else fmul = {s, e[7:0], m[22:0]};
        end
      end
    end
  endfunction

  // IEEE single add, round to nearest even, canonical NaN.
  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    logic [7:0]  ea, eb, eh;
    logic [26:0] mh, ml, mx;
    logic [27:0] sum;
    logic [7:0]  d;
    logic        sh_s, sl, st;
    logic [4:0]  lz;
    logic signed [9:0] e;
    logic [24:0] m;
    begin
      ea = a[30:23];
      eb = b[30:23];
      fadd = 32'd0;
      if ((ea == 8'hFF && a[22:0] != 0) || (eb == 8'hFF && b[22:0] != 0)) begin
        fadd = CanonNan;
      end else if (ea == 8'hFF && eb == 8'hFF) begin
        fadd = (a[31] != b[31]) ? CanonNan : a;
      end else if (ea == 8'hFF) begin
        fadd = a;
      end else if (eb == 8'hFF) begin
        fadd = b;
      end else begin
        if (a[30:0] >= b[30:0]) begin
          eh = ea; sh_s = a[31]; sl = b[31];
          mh = {ea != 0, a[22:0], 3'b000};
          ml = {eb != 0, b[22:0], 3'b000};
          d  = (ea == 0 ? 8'd1 : ea) - (eb == 0 ? 8'd1 : eb);
        end else begin
          eh = eb; sh_s = b[31]; sl = a[31];
          mh = {eb != 0, b[22:0], 3'b000};
          ml = {ea != 0, a[22:0], 3'b000};
          d  = (eb == 0 ? 8'd1 : eb) - (ea == 0 ? 8'd1 : ea);
        end
        if (eh == 0) eh = 8'd1;
        if (d > 8'd26) begin
          mx = {26'd0, |ml};
        end else begin
          mx = ml >> d;
          st = |(ml & ~(27'h7FFFFFF << d));
          mx[0] = mx[0] | st;
        end
        if (sh_s == sl) sum = {1'b0, mh} + {1'b0, mx};
        else sum = {1'b0, mh} - {1'b0, mx};
        e = {2'b00, eh};
        if (sum == 0) begin
          fadd = (a[31] & b[31]) ? 32'h80000000 : 32'd0;
        end else begin
          if (sum[27]) begin
            sum = {1'b0, sum[27:2], sum[1] | sum[0]};
            e = e + 10'sd1;
          end
          lz = 5'd0;
          for (int i = 26; i >= 0; i--) begin
            if (sum[i] && lz == 5'd0) lz = 5'(27 - i);
          end
          lz = lz - 5'd1;
          // The exponent never drops below the subnormal exponent of one.
          if (10'(lz) >= e) lz = 5'(e - 10'sd1);
          sum = sum << lz;
          e = e - 10'(lz);
          m = {1'b0, sum[26:3]};
          if (sum[2] && (sum[1] || sum[0] || m[0])) m = m + 25'd1;
          if (m[24]) begin
            m = m >> 1;
            e = e + 10'sd1;
          end
          if (e >= 10'sd255) fadd = {sh_s, 8'hFF, 23'd0};
          else if (!m[23]) fadd = {sh_s, 8'd0, m[22:0]};
          else fadd = {sh_s, e[7:0], m[22:0]};
        end
      end
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/affine_matrix_concat_3x4.sv =====
// Throughput: one load word per cycle while idle; a start word stalls the input until
// the last of the twelve results has been taken at the output.
// Each product element runs three multiplies and up to three adds through one
// shared multiplier and one shared adder under a sequencer.
// Reset clears the sequencer and the output valid; matrix stores are not cleared.
`default_nettype none
module affine_matrix_concat_3x4 (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire amc_pkg::in_word_t  in_data,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output amc_pkg::out_word_t      out_data
);
  amc_pkg::dp_cmd_t  cmd;
  amc_pkg::dp_stat_t stat;
  logic [31:0]       acc;

  amc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_data(in_data),
    .in_stall(in_stall), .cmd(cmd), .stat(stat), .acc(acc),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  amc_dp u_dp (
    .clk(clk), .cmd(cmd), .wr_data(in_data.element_value), .stat(stat), .acc(acc)
  );
endmodule
`default_nettype wire

// ===== rtl/amc_dp.sv =====
`default_nettype none
module amc_dp (
  input  wire logic              clk,
  input  wire amc_pkg::dp_cmd_t  cmd,
  input  wire logic [31:0]       wr_data,
  output amc_pkg::dp_stat_t      stat,
  output logic [31:0]            acc
);
  logic [31:0] mem_a [0:11];
  logic [31:0] mem_b [0:11];
  logic [31:0] acc_r, acc_nxt, prod_r, prod_nxt;
  logic [31:0] opa_r, opb_r;
  logic [3:0]  ia, ib;
  logic        mul_v_r, add_v_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      if (cmd.wr_idx < 5'd12) mem_a[cmd.wr_idx[3:0]] <= wr_data;
      else if (cmd.wr_idx < 5'd24) mem_b[4'(cmd.wr_idx - 5'd12)] <= wr_data;
    end
  end

  // Element k of the dot product: a[row][k] times b[k][col].
  always_comb begin
    ia = 4'({cmd.row, 2'b00}) + 4'(cmd.op);
    ib = 4'({cmd.op[1:0], 2'b00}) + 4'(cmd.col);
    if (cmd.op == amc_pkg::OP_ADDT) ib = 4'd0;
  end

  // Operands are read into registers in the cycle before the issue.
  always_ff @(posedge clk) begin
    opa_r <= mem_a[ia];
    opb_r <= mem_b[ib];
  end

  always_comb begin
    prod_nxt = amc_pkg::fmul(opa_r, opb_r);
    acc_nxt  = amc_pkg::fadd(acc_r, prod_r);
  end

  // Products after the first are registered, then folded in.
  always_ff @(posedge clk) begin
    mul_v_r <= cmd.op_en && (cmd.op != amc_pkg::OP_MUL0);
    add_v_r <= mul_v_r;
    if (mul_v_r) acc_r <= acc_nxt;
    else if (cmd.op_en && cmd.op == amc_pkg::OP_MUL0) acc_r <= prod_nxt;
    if (cmd.op_en) begin
      if (cmd.op == amc_pkg::OP_ADDT) prod_r <= opa_r;
      else if (cmd.op != amc_pkg::OP_MUL0) prod_r <= prod_nxt;
    end
  end

  assign stat.add_done = add_v_r;
  assign acc = acc_r;
endmodule
`default_nettype wire

// ===== rtl/amc_ctrl.sv =====
`default_nettype none
module amc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire amc_pkg::in_word_t  in_data,
  output logic                    in_stall,
  output amc_pkg::dp_cmd_t        cmd,
  input  wire amc_pkg::dp_stat_t  stat,
  input  wire logic [31:0]        acc,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output amc_pkg::out_word_t      out_data
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_ISSUE = 6'b000100,
    S_WAIT = 6'b001000,
    S_OUT = 6'b010000,
    S_DRAIN = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] row_r, row_nxt, col_r, col_nxt;
  amc_pkg::op_t op_r, op_nxt;
  logic out_v_r, out_v_nxt;
  amc_pkg::out_word_t out_r;
  logic in_acc;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    row_nxt = row_r;
    col_nxt = col_r;
    op_nxt = op_r;
    out_v_nxt = out_v_r && out_stall;
    cmd.wr_en = in_acc;
    cmd.wr_idx = in_data.element_index;
    cmd.op_en = 1'b0;
    cmd.op = op_r;
    cmd.row = row_r;
    cmd.col = col_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_data.start_compute) begin
          state_nxt = S_READ;
          row_nxt = 2'd0;
          col_nxt = 2'd0;
          op_nxt = amc_pkg::OP_MUL0;
        end
      end
      S_READ: begin
        state_nxt = S_ISSUE;
      end
      S_ISSUE: begin
        cmd.op_en = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (stat.add_done || op_r == amc_pkg::OP_MUL0) begin
          if (op_r == amc_pkg::OP_MAC2 && col_r != 2'd3) state_nxt = S_OUT;
          else if (op_r == amc_pkg::OP_ADDT) state_nxt = S_OUT;
          else begin
            op_nxt = amc_pkg::op_t'(op_r + 2'd1);
            state_nxt = S_READ;
          end
        end
      end
      S_OUT: begin
        if (!out_v_r || !out_stall) begin
          out_v_nxt = 1'b1;
          op_nxt = amc_pkg::OP_MUL0;
          if (row_r == 2'd2 && col_r == 2'd3) state_nxt = S_DRAIN;
          else begin
            state_nxt = S_READ;
            col_nxt = col_r + 2'd1;
            if (col_r == 2'd3) row_nxt = row_r + 2'd1;
          end
        end
      end
      S_DRAIN: begin
        if (!out_v_r) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_v_r <= 1'b0;
      row_r <= 2'd0;
      col_r <= 2'd0;
      op_r <= amc_pkg::OP_MUL0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
      row_r <= row_nxt;
      col_r <= col_nxt;
      op_r <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && (!out_v_r || !out_stall)) begin
      out_r.result_row <= row_r;
      out_r.result_col <= col_r;
      out_r.result_value <= acc;
      out_r.result_last <= (row_r == 2'd2 && col_r == 2'd3);
    end
  end

  assign out_valid = out_v_r;
  assign out_data = out_r;
endmodule
`default_nettype wire

// ===== rtl/amc_checker.sv =====
`default_nettype none
module amc_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire amc_pkg::in_word_t  in_data,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire amc_pkg::out_word_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  a_start_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.start_compute |=> in_stall)
    else $error("input not stalled after start");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.result_row != 2'd3)
    else $error("row out of range");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_last |-> out_data.result_row == 2'd2 &&
      out_data.result_col == 2'd3)
    else $error("last flag misplaced");
endmodule

bind affine_matrix_concat_3x4 amc_checker u_amc_checker (.*);
`default_nettype wire

// ===== dv/affine_matrix_concat_3x4_checker.sv =====
module affine_matrix_concat_3x4_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  amc_pkg::in_word_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  amc_pkg::out_word_t out_data,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] left_elems [amc_pkg::MatElems];
  logic [31:0] right_elems [amc_pkg::MatElems];
  amc_pkg::out_word_t product_q [$];

  // Widen a single word to a double; every single value is exact there.
  function automatic real single_to_real(input logic [31:0] w);
    logic [63:0] d;
    logic [23:0] m;
    int e;
    begin
      m = {1'b0, w[22:0]};
      e = w[30:23];
      if (w[30:23] == 8'hFF) begin
        d = (w[22:0] != 0) ? 64'h7FF8000000000000 : {w[31], 11'h7FF, 52'd0};
      end else if (w[30:0] == 0) begin
        d = {w[31], 63'd0};
      end else begin
        if (e == 0) begin
          e = 1;
          while (!m[23]) begin
            m = m << 1;
            e = e - 1;
          end
        end
        d = {w[31], 11'(e - 127 + 1023), w[30:23] == 0 ? m[22:0] : w[22:0], 29'd0};
      end
      single_to_real = $bitstoreal(d);
    end
  endfunction

  // Round a double to single precision, nearest even, gradual underflow.
  // A double sum or product of two singles rounded once more this way is
  // correctly rounded, since a double carries more than twice the bits.
  function automatic logic [31:0] real_to_single(input real x);
    logic [63:0] d;
    logic [63:0] sig;
    logic [63:0] m;
    logic s, g, st;
    int ue, eb, sh;
    begin
      d = $realtobits(x);
      s = d[63];
      if (d[62:52] == 11'h7FF) begin
        real_to_single = (d[51:0] != 0) ? amc_pkg::CanonNan : {s, 8'hFF, 23'd0};
      end else if (d[62:52] == 0) begin
        real_to_single = {s, 31'd0};
      end else begin
        ue = int'(d[62:52]) - 1023;
        eb = ue + 127;
        sig = {11'd0, 1'b1, d[51:0]};
        if (eb >= 1) begin
          m = sig >> 29;
          g = sig[28];
          st = |sig[27:0];
          if (g && (st || m[0])) m = m + 1;
          if (m[24]) begin
            m = m >> 1;
            eb = eb + 1;
          end
          real_to_single = (eb >= 255) ? {s, 8'hFF, 23'd0} : {s, 8'(eb), m[22:0]};
        end else begin
          sh = -97 - ue;
          if (sh > 60) begin
            m = 0;
            g = 1'b0;
            st = 1'b1;
          end else begin
            m = sig >> sh;
            g = sig[sh-1];
            st = (sig & ((64'd1 << (sh - 1)) - 1)) != 0;
          end
          if (g && (st || m[0])) m = m + 1;
          real_to_single = {s, 31'(m)};
        end
      end
    end
  endfunction

  function automatic logic [31:0] mul_single(input logic [31:0] a, input logic [31:0] b);
    mul_single = real_to_single(single_to_real(a) * single_to_real(b));
  endfunction

  function automatic logic [31:0] add_single(input logic [31:0] a, input logic [31:0] b);
    add_single = real_to_single(single_to_real(a) + single_to_real(b));
  endfunction

  function automatic logic [31:0] concat_elem(input int r, input int c);
    logic [31:0] acc;
    begin
      acc = add_single(mul_single(left_elems[r*4], right_elems[c]),
                       mul_single(left_elems[r*4+1], right_elems[4+c]));
      acc = add_single(acc, mul_single(left_elems[r*4+2], right_elems[8+c]));
      if (c == 3) acc = add_single(acc, left_elems[r*4+3]);
      concat_elem = acc;
    end
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch in %s: got %h, expected %h", what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    amc_pkg::out_word_t want;
    if (rst_n && in_valid && !in_stall) begin
      if (in_data.element_index < 12)
        left_elems[in_data.element_index[3:0]] = in_data.element_value;
      else if (in_data.element_index < 24)
        right_elems[4'(in_data.element_index - 5'd12)] = in_data.element_value;
      if (in_data.start_compute) begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 4; c++) begin
            want.result_row = 2'(r);
            want.result_col = 2'(c);
            want.result_value = concat_elem(r, c);
            want.result_last = (r == 2 && c == 3);
            product_q.push_back(want);
          end
        end
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      if (product_q.size() == 0) begin
        report("unexpected word", out_data.result_value, 32'd0);
      end else begin
        want = product_q.pop_front();
        if (out_data.result_row !== want.result_row)
          report("row", 32'(out_data.result_row), 32'(want.result_row));
        if (out_data.result_col !== want.result_col)
          report("column", 32'(out_data.result_col), 32'(want.result_col));
        if (out_data.result_value !== want.result_value)
          report("value", out_data.result_value, want.result_value);
        if (out_data.result_last !== want.result_last)
          report("last flag", 32'(out_data.result_last), 32'(want.result_last));
      end
    end
    pending = product_q.size();
  end
endmodule

// ===== dv/affine_matrix_concat_3x4_tb.sv =====
module affine_matrix_concat_3x4_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  amc_pkg::in_word_t in_data = '0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  amc_pkg::out_word_t out_data;
  int fail_count;
  int pending;
  int cycles = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  affine_matrix_concat_3x4 uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_data(in_data), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  affine_matrix_concat_3x4_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Stretches without any stall are mixed at random with stretches of random stalls.
  always @(posedge clk) begin
    if (cycles % 300 == 0) quiet = ($urandom_range(0, 3) == 0);
    if (rst_n) begin
      if (out_valid && !out_stall) stall_left = quiet ? 0 : $urandom_range(0, 7);
      else if (stall_left > 0) stall_left--;
      out_stall <= (stall_left > 0);
    end
  end

  function automatic logic [31:0] pick_value();
    logic [31:0] specials [10] = '{32'h7F7FFFFF, 32'h00000001, 32'h7F800000, 32'h7FC00001,
                                    32'h80000000, 32'h00000000, 32'h007FFFFF, 32'h00800000,
                                    32'h3F800000, 32'hFF800000};
    logic s;
    begin
      s = $urandom_range(0, 1);
      case ($urandom_range(0, 9))
        0, 1: pick_value = $urandom;
        2: pick_value = specials[$urandom_range(0, 9)] ^ {s, 31'd0};
        3: pick_value = {s, 8'd0, 23'($urandom)};
        4: pick_value = {s, 8'($urandom_range(240, 254)), 23'($urandom)};
        5: pick_value = {s, 8'($urandom_range(1, 20)), 23'($urandom)};
        default: pick_value = {s, 8'($urandom_range(118, 136)), 23'($urandom)};
      endcase
    end
  endfunction

  task automatic send_word(input int idx, input logic [31:0] val, input bit start);
    int gap;
    begin
      gap = quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data <= '{element_index: 5'(idx), element_value: val, start_compute: start};
      forever begin
        @(negedge clk);
        if (!in_stall) break;
      end
      @(posedge clk);
    end
  endtask

  // Writes all 24 elements in a shuffled order; the last word starts the product.
  task automatic load_all(input bit use_specials);
    int order [24];
    int j, t;
    begin
      foreach (order[i]) order[i] = i;
      for (int i = 23; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = order[i];
        order[i] = order[j];
        order[j] = t;
      end
      for (int i = 0; i < 24; i++)
        send_word(order[i], use_specials ? pick_value() : $urandom, i == 23);
    end
  endtask

  task automatic drain();
    begin
      in_valid <= 1'b0;
      @(posedge clk);
      wait (pending == 0);
      repeat (30) @(posedge clk);
    end
  endtask

  initial begin
    int n;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extremes and special values across every slot.
    for (int i = 0; i < 24; i++)
      send_word(i, i[0] ? 32'hFFFFFFFF : (i < 12 ? 32'h7F7FFFFF : 32'h00000001), 1'b0);
    send_word(31, 32'h0, 1'b1);
    send_word(5, 32'h7FC00000, 1'b1);
    send_word(17, 32'h7F800000, 1'b0);
    send_word(3, 32'h00000000, 1'b1);
    send_word(8, 32'h80000000, 1'b1);
    drain();

    for (int k = 0; k < 6; k++) load_all(k != 0);
    drain();

    // Mostly partial updates of a fully written pair, with noise words between.
    n = 0;
    while (n < 170) begin
      for (int i = $urandom_range(0, 5); i > 0; i--) begin
        if ($urandom_range(0, 7) == 0) send_word($urandom_range(24, 31), $urandom, 1'b0);
        else send_word($urandom_range(0, 23), pick_value(), 1'b0);
        n++;
      end
      if ($urandom_range(0, 5) == 0) send_word($urandom_range(24, 31), $urandom, 1'b1);
      else send_word($urandom_range(0, 23), pick_value(), 1'b1);
      n++;
      if ($urandom_range(0, 15) == 0) drain();
    end
    load_all(1'b1);

    drain();
    if (fail_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/amc_pkg.sv
rtl/amc_dp.sv
rtl/amc_ctrl.sv
rtl/affine_matrix_concat_3x4.sv
rtl/amc_checker.sv
dv/affine_matrix_concat_3x4_checker.sv
dv/affine_matrix_concat_3x4_tb.sv
